@@ rtl/dht_pkg.sv @@
// ----------------------------------------------------------------------------
// dht_pkg
// Shared widths, register map, status codes and sequencer states of the
// double-hashing hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int unsigned KeyW      = 31;
  localparam int unsigned SlotW     = 10;
  localparam int unsigned CollW     = 11;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned ModW      = 10;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PAddrW    = 3;
  localparam int unsigned DivCntW   = 4;
  localparam int unsigned DefTableDepth = 1024;

  localparam logic [SizeW-1:0] TableSizeRst = SizeW'(13);
  localparam logic [ModW-1:0]  SecondModRst = ModW'(11);

  localparam logic [PAddrW-1:0] AddrTableSize = PAddrW'(0);
  localparam logic [PAddrW-1:0] AddrSecondMod = PAddrW'(4);

  localparam logic [DivCntW-1:0] DivPairsKey  = DivCntW'(15);
  localparam logic [DivCntW-1:0] DivPairsWrap = DivCntW'(4);

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_STEP,
    S_WRAP,
    S_READ,
    S_CHECK
  } state_e;

endpackage

@@ rtl/double_hash_table_insert_search.sv @@
// ----------------------------------------------------------------------------
// double_hash_table_insert_search
// Open-addressing hash table of nonzero keys with double hashing, built on
// one shared two-bit-per-cycle divider and a slot memory with one write port and one read port.
// ----------------------------------------------------------------------------
// After reset the block sweeps every slot of the memory to zero with busy
// high. A request (start high while busy low) then keeps busy high while the
// shared divider reduces key mod m, then key mod q, then the step mod m, and
// while each probed slot takes a memory read step and a check step. The
// result shows on the result ports with done_o high for exactly one cycle,
// in the cycle busy falls; it cannot be held off, so capture it then.
module double_hash_table_insert_search
  import dht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              op_i,
  input  logic [KeyW-1:0]   key_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [SlotW-1:0]  slot_o,
  output logic [KeyW-1:0]   key_out_o,
  output logic [CollW-1:0]  collisions_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_e state_q, state_d;

  logic [SizeW-1:0] table_size_q;
  logic [ModW-1:0]  second_mod_q;

  logic [SizeW-1:0] m_eff, m_q, m_d;
  logic [ModW-1:0]  q_eff, q_q, q_d;
  logic             op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;

  logic [DataW-1:0]   div_num_q, div_num_d;
  logic [SizeW-1:0]   div_rem_q, div_rem_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [SizeW-1:0]   div_den;
  logic [SizeW:0]     div_t1, div_t2;
  logic [SizeW-1:0]   div_r1;
  logic [SizeW-1:0]   div_res;
  logic               div_last;
  logic [ModW-1:0]    step_raw;

  logic [SizeW-1:0] pos_q, pos_d;
  logic [SizeW-1:0] step_q, step_d;
  logic [CollW-1:0] coll_q, coll_d;
  logic [SizeW:0]   pos_sum;
  logic [SizeW-1:0] pos_next;

  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_last;

  logic [KeyW-1:0]  mem_q [TABLE_DEPTH];
  logic [KeyW-1:0]  rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [KeyW-1:0]  mem_wdata;

  logic             accept;
  logic             cfg_wr;
  logic             slot_empty, key_hit, path_end, finish;

  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [KeyW-1:0]  kout_q, kout_d;
  logic [CollW-1:0] coll_out_q, coll_out_d;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr)
      AddrTableSize: prdata = DataW'(table_size_q);
      AddrSecondMod: prdata = DataW'(second_mod_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableSizeRst;
      second_mod_q <= SecondModRst;
    end else if (cfg_wr) begin
      if (paddr == AddrTableSize) begin
        table_size_q <= pwdata[SizeW-1:0];
      end
      if (paddr == AddrSecondMod) begin
        second_mod_q <= pwdata[ModW-1:0];
      end
    end
  end

  always_comb begin
    if (table_size_q == '0) begin
      m_eff = SizeW'(1);
    end else if (DataW'(table_size_q) > DataW'(TABLE_DEPTH)) begin
      m_eff = SizeW'(TABLE_DEPTH);
    end else begin
      m_eff = table_size_q;
    end
    q_eff = (second_mod_q == '0) ? ModW'(1) : second_mod_q;
  end

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  // Shared divider: two restoring steps per cycle
  always_comb begin
    div_den = (state_q == S_STEP) ? SizeW'(q_q) : m_q;
    div_t1  = {div_rem_q, div_num_q[DataW-1]};
    div_r1  = (div_t1 >= {1'b0, div_den}) ? SizeW'(div_t1 - {1'b0, div_den})
                                          : div_t1[SizeW-1:0];
    div_t2  = {div_r1, div_num_q[DataW-2]};
    div_res = (div_t2 >= {1'b0, div_den}) ? SizeW'(div_t2 - {1'b0, div_den})
                                          : div_t2[SizeW-1:0];
    div_last = (div_cnt_q == '0);
    step_raw = q_q - ModW'(div_res);
  end

  // Probe path
  assign pos_sum    = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_next   = (pos_sum >= {1'b0, m_q}) ? SizeW'(pos_sum - {1'b0, m_q})
                                               : pos_sum[SizeW-1:0];
  assign slot_empty = (rdata_q == '0);
  assign key_hit    = (op_q == OP_SEARCH) && (rdata_q == key_q);
  assign path_end   = ((coll_q + CollW'(1)) == CollW'(m_q));
  assign finish     = slot_empty || key_hit || path_end;
  assign clr_last   = (clr_cnt_q == AddrW'(TABLE_DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_HOME;
      S_HOME:  if (div_last) state_d = S_STEP;
      S_STEP:  if (div_last) state_d = S_WRAP;
      S_WRAP:  if (div_last) state_d = S_READ;
      S_READ:  state_d = S_CHECK;
      S_CHECK: state_d = finish ? S_IDLE : S_READ;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    m_d        = m_q;
    q_d        = q_q;
    op_d       = op_q;
    key_d      = key_q;
    div_num_d  = {div_num_q[DataW-3:0], 2'b00};
    div_rem_d  = div_res;
    div_cnt_d  = div_cnt_q - DivCntW'(1);
    pos_d      = pos_q;
    step_d     = step_q;
    coll_d     = coll_q;
    clr_cnt_d  = clr_cnt_q;
    mem_we     = 1'b0;
    mem_waddr  = AddrW'(pos_q);
    mem_wdata  = key_q;
    done_d     = 1'b0;
    status_d   = status_q;
    slot_d     = slot_q;
    kout_d     = kout_q;
    coll_out_d = coll_out_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
      end
      S_IDLE: begin
        m_d       = m_eff;
        q_d       = q_eff;
        op_d      = op_i;
        key_d     = key_i;
        div_num_d = {1'b0, key_i};
        div_cnt_d = DivPairsKey;
        coll_d    = '0;
      end
      S_HOME: begin
        if (div_last) begin
          pos_d     = div_res;
          div_num_d = {1'b0, key_q};
          div_cnt_d = DivPairsKey;
        end
      end
      S_STEP: begin
        if (div_last) begin
          div_num_d = {step_raw, (DataW - ModW)'(0)};
          div_cnt_d = DivPairsWrap;
        end
      end
      S_WRAP: begin
        if (div_last) begin
          step_d = div_res;
        end
      end
      S_READ: begin
      end
      S_CHECK: begin
        if (slot_empty) begin
          done_d     = 1'b1;
          coll_out_d = coll_q;
          kout_d     = '0;
          if (op_q == OP_SEARCH) begin
            status_d = STATUS_NOT_FOUND;
            slot_d   = '0;
          end else begin
            status_d = STATUS_INSERTED;
            slot_d   = pos_q[SlotW-1:0];
            mem_we   = 1'b1;
          end
        end else if (key_hit) begin
          done_d     = 1'b1;
          status_d   = STATUS_FOUND;
          slot_d     = pos_q[SlotW-1:0];
          kout_d     = rdata_q;
          coll_out_d = coll_q;
        end else begin
          coll_d = coll_q + CollW'(1);
          pos_d  = pos_next;
          if (path_end) begin
            done_d     = 1'b1;
            status_d   = (op_q == OP_SEARCH) ? STATUS_NOT_FOUND : STATUS_FULL;
            slot_d     = '0;
            kout_d     = '0;
            coll_out_d = CollW'(m_q);
          end
        end
      end
      default: begin
      end
    endcase

    if (state_q == S_HOME || state_q == S_STEP || state_q == S_WRAP) begin
      if (div_last) begin
        div_rem_d = '0;
      end
    end else begin
      div_rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    q_q        <= q_d;
    op_q       <= op_d;
    key_q      <= key_d;
    div_num_q  <= div_num_d;
    div_rem_q  <= div_rem_d;
    div_cnt_q  <= div_cnt_d;
    pos_q      <= pos_d;
    step_q     <= step_d;
    coll_q     <= coll_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
    kout_q     <= kout_d;
    coll_out_q <= coll_out_d;
  end

  // Slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[AddrW'(pos_q)];
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign key_out_o    = kout_q;
  assign collisions_o = coll_out_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted but sequencer stayed idle");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_CHECK) |-> (pos_q < m_q))
    else $error("probe position outside table");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STATUS_FULL) |-> (collisions_o == CollW'(m_q)))
    else $error("full status without a complete probe path");

  a_hit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FOUND || status_o == STATUS_INSERTED))
      |-> (SizeW'(slot_o) < m_q))
    else $error("reported slot outside table");
`endif

endmodule
